// File: src/distinct_id_counter_assert.svh
// Assertion helpers used by the dic_search module.
`ifndef DISTINCT_ID_COUNTER_ASSERT_SVH
`define DISTINCT_ID_COUNTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DIC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("distinct_id_counter assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DIC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("distinct_id_counter assertion failed");

`endif

// File: src/dic_pkg.sv
`default_nettype none

package dic_pkg;

  localparam int unsigned CLASS_W = 8;
  localparam int unsigned IDENT_W = 64;
  localparam int unsigned TOTAL_W = 32;

  localparam logic [CLASS_W-1:0] CLASS_RESET = 8'd1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX   = '1;

  typedef struct packed {
    logic               is_new_object;
    logic [TOTAL_W-1:0] running_total;
    logic               table_full;
  } dic_res_t;

endpackage

`default_nettype wire

// File: src/dic_in_if.sv
`default_nettype none

interface dic_in_if;
  import dic_pkg::*;

  logic               valid;
  logic               ready;
  logic [CLASS_W-1:0] object_class;
  logic [IDENT_W-1:0] object_ident;

  modport source (output valid, output object_class, output object_ident, input ready);
  modport sink   (input valid, input object_class, input object_ident, output ready);

endinterface

`default_nettype wire

// File: src/dic_out_if.sv
`default_nettype none

interface dic_out_if;
  import dic_pkg::*;

  logic               valid;
  logic               ready;
  logic               is_new_object;
  logic [TOTAL_W-1:0] running_total;
  logic               table_full;

  modport source (output valid, output is_new_object, output running_total,
                  output table_full, input ready);
  modport sink   (input valid, input is_new_object, input running_total,
                  input table_full, output ready);

endinterface

`default_nettype wire

// File: src/dic_ident_mem.sv
`default_nettype none

module dic_ident_mem #(
  parameter int unsigned TABLE_DEPTH = 1024,
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        wr_en_i,
  input  wire logic [AW-1:0]               wr_addr_i,
  input  wire logic [dic_pkg::IDENT_W-1:0] wr_data_i,
  input  wire logic                        rd_en_i,
  input  wire logic [AW-1:0]               rd_addr_i,
  output logic      [dic_pkg::IDENT_W-1:0] rd_data_o
);
  import dic_pkg::*;

  logic [IDENT_W-1:0] mem_q [TABLE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// File: src/dic_search.sv
`default_nettype none

module dic_search #(
  parameter int unsigned TABLE_DEPTH = 1024,
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int unsigned FW = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [dic_pkg::CLASS_W-1:0] counted_class_i,
  dic_in_if.sink                           obj_i,
  output logic                             res_valid_o,
  input  wire logic                        res_ready_i,
  output dic_pkg::dic_res_t                res_o,
  output logic                             rd_en_o,
  output logic      [AW-1:0]               rd_addr_o,
  input  wire logic [dic_pkg::IDENT_W-1:0] rd_data_i,
  output logic                             wr_en_o,
  output logic      [AW-1:0]               wr_addr_o,
  output logic      [dic_pkg::IDENT_W-1:0] wr_data_o
);
  import dic_pkg::*;

  localparam logic [FW-1:0] DEPTH_C = FW'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_HOLD
  } state_e;

  state_e             state_q, state_d;
  logic [IDENT_W-1:0] ident_q, ident_d;
  logic [FW-1:0]      idx_q, idx_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic               fresh_q, fresh_d;
  logic [FW-1:0]      fill_q, fill_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic               ovf_q, ovf_d;
  logic               full;
  logic               issue;

  assign full  = (fill_q == DEPTH_C);
  assign issue = (state_q == ST_SCAN) && (idx_q != fill_q);

  assign obj_i.ready = (state_q == ST_IDLE);

  assign rd_en_o   = issue;
  assign rd_addr_o = idx_q[AW-1:0];
  assign wr_en_o   = (state_q == ST_COMMIT) && fresh_q && !full;
  assign wr_addr_o = fill_q[AW-1:0];
  assign wr_data_o = ident_q;

  assign res_valid_o         = (state_q == ST_HOLD);
  assign res_o.is_new_object = fresh_q;
  assign res_o.running_total = total_q;
  assign res_o.table_full    = full;

  always_comb begin
    state_d   = state_q;
    ident_d   = ident_q;
    idx_d     = idx_q;
    cmp_vld_d = 1'b0;
    fresh_d   = fresh_q;
    fill_d    = fill_q;
    total_d   = total_q;
    ovf_d     = ovf_q;
    unique case (state_q)
      ST_IDLE: begin
        if (obj_i.valid) begin
          ident_d = obj_i.object_ident;
          idx_d   = '0;
          if (obj_i.object_class != counted_class_i) begin
            fresh_d = 1'b0;
            state_d = ST_COMMIT;
          end else if (fill_q == '0) begin
            fresh_d = 1'b1;
            state_d = ST_COMMIT;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmp_vld_d = issue;
        if (issue) begin
          idx_d = idx_q + 1'b1;
        end
        if (cmp_vld_q && (rd_data_i == ident_q)) begin
          fresh_d = 1'b0;
          state_d = ST_COMMIT;
        end else if (cmp_vld_q && !issue) begin
          fresh_d = 1'b1;
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (fresh_q) begin
          if (total_q != TOTAL_MAX) begin
            total_d = total_q + 1'b1;
          end
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            fill_d = fill_q + 1'b1;
          end
        end
        state_d = ST_HOLD;
      end
      ST_HOLD: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      cmp_vld_q <= 1'b0;
      fresh_q   <= 1'b0;
      fill_q    <= '0;
      total_q   <= '0;
      ovf_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      cmp_vld_q <= cmp_vld_d;
      fresh_q   <= fresh_d;
      fill_q    <= fill_d;
      total_q   <= total_d;
      ovf_q     <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ident_q <= ident_d;
  end

`include "distinct_id_counter_assert.svh"

  `DIC_ASSERT_IMPL(a_fill_bound, clk_i, rst_ni, 1'b1, fill_q <= DEPTH_C)
  `DIC_ASSERT_IMPL(a_ovf_full, clk_i, rst_ni, ovf_q, full)
  `DIC_ASSERT_IMPL(a_read_in_fill, clk_i, rst_ni, rd_en_o, idx_q < fill_q)
  `DIC_ASSERT_NEXT(a_total_hold, clk_i, rst_ni, state_q != ST_COMMIT, total_q == $past(total_q))
  `DIC_ASSERT_IMPL(a_write_commit, clk_i, rst_ni, wr_en_o, fresh_q && (state_q == ST_COMMIT))

endmodule

`default_nettype wire

// File: src/distinct_id_counter.sv
// Counts distinct 64-bit object identifiers of the class held in the counted-class register
// (reset value 1, written whenever cfg_we_i is high). Every input transfer yields exactly one
// result transfer carrying the new-object flag, the saturating 32-bit total and the table-full
// flag. A matching item is compared against the stored identifiers in turn, until one matches,
// through the single read port of the identifier memory, one entry per cycle; the block takes
// no new item until the scan ends and its result is handed over. An item of another class, or
// any item while the table is empty, skips the scan. Once TABLE_DEPTH identifiers are stored,
// further new identifiers are counted but not stored, so a repeat of one counts again.
`default_nettype none

module distinct_id_counter #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [dic_pkg::CLASS_W-1:0] cfg_wdata_i,
  dic_in_if.sink                           obj_i,
  dic_out_if.source                        res_o
);
  import dic_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [CLASS_W-1:0] counted_class_q;
  logic               res_valid;
  logic               res_ready;
  dic_res_t           res;
  dic_res_t           out_q;
  logic               out_vld_q;

  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [IDENT_W-1:0] rd_data;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [IDENT_W-1:0] wr_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counted_class_q <= CLASS_RESET;
    end else if (cfg_we_i) begin
      counted_class_q <= cfg_wdata_i;
    end
  end

  dic_search #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_search (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .counted_class_i (counted_class_q),
    .obj_i           (obj_i),
    .res_valid_o     (res_valid),
    .res_ready_i     (res_ready),
    .res_o           (res),
    .rd_en_o         (rd_en),
    .rd_addr_o       (rd_addr),
    .rd_data_i       (rd_data),
    .wr_en_o         (wr_en),
    .wr_addr_o       (wr_addr),
    .wr_data_o       (wr_data)
  );

  dic_ident_mem #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // The output register frees the search as soon as a result is handed over.
  assign res_ready = !out_vld_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign res_o.valid         = out_vld_q;
  assign res_o.is_new_object = out_q.is_new_object;
  assign res_o.running_total = out_q.running_total;
  assign res_o.table_full    = out_q.table_full;

endmodule

`default_nettype wire
